// ===== src/avrx_pkg.sv =====
// Shared constants and types for the AVR instruction execute subset.
package avrx_pkg;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned REG_W      = 8;
  localparam int unsigned REG_CNT    = 32;
  localparam int unsigned RADDR_W    = $clog2(REG_CNT);
  localparam int unsigned PC_W       = 14;
  localparam int unsigned PC_SPAN    = 16384;
  localparam int unsigned JMP_W      = 22;
  localparam int unsigned IOA_W      = 6;
  localparam int unsigned CYC_W      = 2;
  localparam int unsigned FLASH_WORDS_DEF = 16384;

  // Opcode patterns
  localparam logic [5:0]  OPC_EOR_TOP  = 6'h09;
  localparam logic [3:0]  OPC_LDI_TOP  = 4'hE;
  localparam logic [4:0]  OPC_OUT_TOP  = 5'b10111;
  localparam logic [15:0] OPC_JMP_MASK = 16'hFE0E;
  localparam logic [15:0] OPC_JMP_VAL  = 16'h940C;

  // Status register handling
  localparam logic [IOA_W-1:0] SREG_IO_ADDR = 6'h3F;
  localparam logic [REG_W-1:0] SREG_EOR_KEEP = 8'hE1;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_S = 4;

  // Cycle counts reported per instruction class
  localparam logic [CYC_W-1:0] CYC_FAULT = 2'd0;
  localparam logic [CYC_W-1:0] CYC_ONE   = 2'd1;
  localparam logic [CYC_W-1:0] CYC_JMP   = 2'd3;

  typedef logic [RADDR_W-1:0] raddr_t;
  typedef logic [REG_W-1:0]   rdata_t;

  // Register file write request
  typedef struct packed {
    logic   en;
    raddr_t addr;
    rdata_t data;
  } rf_wr_t;

endpackage

// ===== src/avrx_rf.sv =====
// Register file: 32 x 8 bits, two registered read ports, one write port.
module avrx_rf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  avrx_pkg::raddr_t rd_a_addr,
  input  avrx_pkg::raddr_t rd_b_addr,
  input  avrx_pkg::rf_wr_t wr,
  output avrx_pkg::rdata_t rd_a_data,
  output avrx_pkg::rdata_t rd_b_data
);
  import avrx_pkg::*;

  rdata_t             mem_r [REG_CNT];
  logic [REG_CNT-1:0] vld_r;
  rdata_t             rd_a_data_r;
  rdata_t             rd_b_data_r;

  // Mark entries written since reset; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Store write data
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // Read both ports, pass a same-edge write through
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_a_addr)) begin
        rd_a_data_r <= wr.data;
      end else if (vld_r[rd_a_addr] && !(!rst_n)) begin
        rd_a_data_r <= mem_r[rd_a_addr];
      end else begin
        rd_a_data_r <= '0;
      end
      if (wr.en && (wr.addr == rd_b_addr)) begin
        rd_b_data_r <= wr.data;
      end else if (vld_r[rd_b_addr] && !(!rst_n)) begin
        rd_b_data_r <= mem_r[rd_b_addr];
      end else begin
        rd_b_data_r <= '0;
      end
    end
  end

  assign rd_a_data = rd_a_data_r;
  assign rd_b_data = rd_b_data_r;

endmodule

// ===== src/avr_instruction_execute_subset.sv =====
// Top level: executes EOR, LDI, OUT and JMP, one instruction item per cycle unless the output stalls.
// Path: an accepted item is read into the operand read register, then executed into the result register.
// Throughput: one item per cycle while no result is held by out_stall; the operand read register and the result
//   register form a two-stage pipe with a same-edge bypass in the register file.
// Reset: synchronous, active low; clears registers, status, program counter and
//   all pipeline valid flags. No clearing pass; the block accepts items at once.
module avr_instruction_execute_subset #(
  parameter int unsigned FLASH_WORDS = avrx_pkg::FLASH_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [avrx_pkg::WORD_W-1:0]    in_instr_word,
  input  logic [avrx_pkg::WORD_W-1:0]    in_following_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [avrx_pkg::PC_W-1:0]      out_new_pc,
  output logic [avrx_pkg::CYC_W-1:0]     out_cycles_taken,
  output logic                           out_fault,
  output logic                           out_io_write,
  output logic [avrx_pkg::IOA_W-1:0]     out_io_addr,
  output logic [avrx_pkg::REG_W-1:0]     out_io_data,
  output logic [avrx_pkg::REG_W-1:0]     out_status_out
);
  import avrx_pkg::*;

  localparam int unsigned PC_LIMIT = (FLASH_WORDS < PC_SPAN) ? FLASH_WORDS : PC_SPAN;
  localparam logic [PC_W-1:0]  PC_LAST      = PC_W'(PC_LIMIT - 1);
  localparam logic [JMP_W:0]   PC_LIMIT_EXT = (JMP_W + 1)'(PC_LIMIT);

  // Pipeline control
  logic in_accept;
  logic s1_valid_r;
  logic out_free;
  logic s1_adv;

  // Operand stage payload
  logic [WORD_W-1:0] s1_op_r;
  logic [WORD_W-1:0] s1_low_r;
  rdata_t            opa;
  rdata_t            opb;

  // Architectural state
  logic [PC_W-1:0]  pc_r;
  logic [PC_W-1:0]  pc_nxt;
  logic [REG_W-1:0] sreg_r;
  logic [REG_W-1:0] sreg_nxt;

  // Result register
  logic              out_valid_r;
  logic [PC_W-1:0]   out_new_pc_r;
  logic [CYC_W-1:0]  out_cycles_r;
  logic              out_fault_r;
  logic              out_io_write_r;
  logic [IOA_W-1:0]  out_io_addr_r;
  logic [REG_W-1:0]  out_io_data_r;
  logic [REG_W-1:0]  out_status_r;

  // Execute results
  rf_wr_t            wr;
  logic [CYC_W-1:0]  cyc;
  logic              fault;
  logic              iow;
  logic [IOA_W-1:0]  ioa;
  logic [REG_W-1:0]  iod;

  // Decode helpers
  logic              is_eor;
  logic              is_ldi;
  logic              is_out;
  logic              is_jmp;
  logic [PC_W-1:0]   pc_inc;
  logic [JMP_W:0]    jmp_target;
  rdata_t            eor_res;

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Register file; read addresses come straight from the incoming word
  avrx_rf u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_accept),
    .rd_a_addr (in_instr_word[8:4]),
    .rd_b_addr ({in_instr_word[9], in_instr_word[3:0]}),
    .wr        (wr),
    .rd_a_data (opa),
    .rd_b_data (opb)
  );

  // Operand stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r  <= in_instr_word;
      s1_low_r <= in_following_word;
    end
  end

  // Decode
  assign is_eor = (s1_op_r[15:10] == OPC_EOR_TOP);
  assign is_ldi = (s1_op_r[15:12] == OPC_LDI_TOP);
  assign is_out = (s1_op_r[15:11] == OPC_OUT_TOP);
  assign is_jmp = ((s1_op_r & OPC_JMP_MASK) == OPC_JMP_VAL);

  assign pc_inc     = (pc_r == PC_LAST) ? '0 : pc_r + 1'b1;
  assign jmp_target = {1'b0, s1_op_r[8:4], s1_op_r[0], s1_low_r};
  assign eor_res    = opa ^ opb;

  // Execute
  always_comb begin
    wr       = '0;
    cyc      = CYC_FAULT;
    fault    = 1'b0;
    iow      = 1'b0;
    ioa      = '0;
    iod      = '0;
    pc_nxt   = pc_r;
    sreg_nxt = sreg_r;
    if (is_eor) begin
      wr.en    = 1'b1;
      wr.addr  = s1_op_r[8:4];
      wr.data  = eor_res;
      sreg_nxt = sreg_r & SREG_EOR_KEEP;
      sreg_nxt[FLAG_N] = eor_res[REG_W-1];
      sreg_nxt[FLAG_S] = eor_res[REG_W-1];
      sreg_nxt[FLAG_Z] = (eor_res == '0);
      pc_nxt   = pc_inc;
      cyc      = CYC_ONE;
    end else if (is_ldi) begin
      wr.en    = 1'b1;
      wr.addr  = {1'b1, s1_op_r[7:4]};
      wr.data  = {s1_op_r[11:8], s1_op_r[3:0]};
      pc_nxt   = pc_inc;
      cyc      = CYC_ONE;
    end else if (is_out) begin
      iow      = 1'b1;
      ioa      = {s1_op_r[10:9], s1_op_r[3:0]};
      iod      = opa;
      if (ioa == SREG_IO_ADDR) begin
        sreg_nxt = opa;
      end
      pc_nxt   = pc_inc;
      cyc      = CYC_ONE;
    end else if (is_jmp) begin
      if (jmp_target < PC_LIMIT_EXT) begin
        pc_nxt = jmp_target[PC_W-1:0];
        cyc    = CYC_JMP;
      end else begin
        fault  = 1'b1;
      end
    end else begin
      fault = 1'b1;
    end
    // Hold state and drop the write unless the item moves on
    if (!s1_adv) begin
      wr.en = 1'b0;
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      sreg_r <= '0;
    end else if (s1_adv) begin
      pc_r   <= pc_nxt;
      sreg_r <= sreg_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_new_pc_r   <= pc_nxt;
      out_cycles_r   <= cyc;
      out_fault_r    <= fault;
      out_io_write_r <= iow;
      out_io_addr_r  <= ioa;
      out_io_data_r  <= iod;
      out_status_r   <= sreg_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_pc       = out_new_pc_r;
  assign out_cycles_taken = out_cycles_r;
  assign out_fault        = out_fault_r;
  assign out_io_write     = out_io_write_r;
  assign out_io_addr      = out_io_addr_r;
  assign out_io_data      = out_io_data_r;
  assign out_status_out   = out_status_r;

`ifndef SYNTH
  // A faulting item reports no cycles and no I/O write
  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fault_r |-> (out_cycles_r == CYC_FAULT) && !out_io_write_r)
    else $error("fault result with cycles or io write");

  // An I/O write always reports the CYC_ONE cycle count
  a_io_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_io_write_r |-> (out_cycles_r == CYC_ONE))
    else $error("io write with wrong cycle count");

  // Input stalls only while the operand stage is full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked pipe");

  // State holds while a result waits on the output
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(pc_r) && $stable(sreg_r))
    else $error("state changed while output stalled");

  // The result's program counter and status match the architectural ones
  a_pc_match: assert property (@(posedge clk) disable iff (!rst_n)
    $past(s1_adv) |-> (out_new_pc_r == pc_r) && (out_status_r == sreg_r))
    else $error("result state differs from architectural state");
`endif

endmodule
